// ----- design/tls_rekey_credit_policer_unit_defines.svh -----
// Assertion macros shared by the policer RTL.
`ifndef TLS_REKEY_CREDIT_POLICER_UNIT_DEFINES_SVH
`define TLS_REKEY_CREDIT_POLICER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TRCP_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed in policer");

// Checks that the consequent holds in the cycle after the antecedent.
`define TRCP_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed in policer");

`endif

// ----- design/trcp_pkg.sv -----
`timescale 1ns / 1ps

package trcp_pkg;

    typedef enum logic [2:0] {
        OP_HEADER    = 3'd0,
        OP_HANDSHAKE = 3'd1,
        OP_RECEIVE   = 3'd2,
        OP_SEND      = 3'd3,
        OP_READY     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    localparam logic [2:0] CFG_CREDIT_CAP         = 3'd0;
    localparam logic [2:0] CFG_WINDOW_TICKS       = 3'd1;
    localparam logic [2:0] CFG_RECORD_CLOSE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_REKEY_BYTE_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_REKEY_RECORD_LIMIT = 3'd4;
    localparam logic [2:0] CFG_CREDIT_EARN_BYTES  = 3'd5;

    localparam logic [5:0]  CREDIT_CAP_RESET         = 6'd32;
    localparam logic [31:0] WINDOW_TICKS_RESET       = 32'd60000;
    localparam logic [22:0] RECORD_CLOSE_LIMIT_RESET = 23'd4194304;
    localparam logic [31:0] REKEY_BYTE_LIMIT_RESET   = 32'd1073741824;
    localparam logic [22:0] REKEY_RECORD_LIMIT_RESET = 23'd1048576;
    localparam logic [28:0] CREDIT_EARN_BYTES_RESET  = 29'd268435456;

    localparam logic [7:0]  KEY_UPDATE_KIND  = 8'd24;
    localparam logic [14:0] MAX_BLOCK_BYTES  = 15'd16384;
    localparam logic [22:0] RECORD_COUNT_MAX = 23'h7FFFFF;
    localparam logic [31:0] WORD_MAX         = 32'hFFFFFFFF;

    localparam int DIV_BITS = 30;

endpackage

// ----- design/tls_rekey_credit_policer_unit.sv -----
`timescale 1ns / 1ps

// Session record and key-update policer.
// Events enter on the s_axis channel (operation in tuser, the rest in tdata) and each
// produces exactly one status item on the m_axis channel, in order.
// Registers are written on the cfg channel, which is always ready; write them only
// while no event is in flight.
// An event taken into the input register has its status registered in the output register
// when it advances; one event is taken every cycle while the receiver does not stall and no
// division runs. A new event is accepted while the previous status still waits in the output
// register.
// A bytes-received event whose sum of held and new bytes reaches twice credit_earn_bytes
// (only possible with credit_earn_bytes below 16384, or after lowering it) runs through
// a bit-serial divider. It stays in the input register while the divider loads, runs and
// reaches its done state, with s_axis_tready low meanwhile, and its status is registered
// when it then advances.
// When the receiver stalls, the status stays in the output register, the event behind it
// waits in the input register, and s_axis_tready drops.
// Reset loads the register reset values, empties both registers and sets the session
// to not ready with 32 credits.
module tls_rekey_credit_policer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // direction[0], message_kind[8:1], byte_count[23:9], time_now[55:24]
    input  logic [55:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // session_closed[0], rekey_needed[1], credits_left[7:2], sent_rekeys[39:8],
    // received_rekeys[71:40]
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "tls_rekey_credit_policer_unit_defines.svh"

    logic [5:0]  credit_cap_reg;
    logic [31:0] window_ticks_reg;
    logic [22:0] record_close_limit_reg;
    logic [31:0] rekey_byte_limit_reg;
    logic [22:0] rekey_record_limit_reg;
    logic [28:0] credit_earn_bytes_reg;

    logic        ready_reg, ready_next;
    logic        closed_reg, closed_next;
    logic [31:0] sent_byte_count_reg, sent_byte_count_next;
    logic [22:0] sent_record_count_reg, sent_record_count_next;
    logic [22:0] received_record_count_reg, received_record_count_next;
    logic [5:0]  credit_count_reg, credit_count_next;
    logic [28:0] earned_byte_count_reg, earned_byte_count_next;
    logic [31:0] window_start_reg, window_start_next;
    logic [31:0] sent_rekey_count_reg, sent_rekey_count_next;
    logic [31:0] received_rekey_count_reg, received_rekey_count_next;

    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic        in_direction_reg;
    logic [7:0]  in_kind_reg;
    logic [14:0] in_bytes_reg;
    logic [31:0] in_time_reg;

    logic        out_valid_reg;
    logic        out_closed_reg;
    logic        out_rekey_reg;
    logic [5:0]  out_credits_reg;
    logic [31:0] out_sent_rekeys_reg;
    logic [31:0] out_received_rekeys_reg;

    trcp_pkg::div_state_t div_state_reg, div_state_next;
    logic [29:0] div_dividend_reg;
    logic [28:0] div_rem_reg;
    logic [29:0] div_quot_reg;
    logic [4:0]  div_count_reg;
    logic        div_load;
    logic        div_done;
    logic        div_last;
    logic [29:0] div_trial;
    logic        div_ge;

    trcp_pkg::op_t op;
    logic        active;
    logic        advance;
    logic        compute_done;
    logic        slow_needed;
    logic        rekey;
    logic [14:0] block_bytes;
    logic        bytes_nonzero;
    logic        is_update;
    logic [22:0] record_sel;
    logic [22:0] record_inc;
    logic [31:0] elapsed;
    logic [5:0]  credit_tmp;
    logic [28:0] unit_eff;
    logic [29:0] rx_sum;
    logic        fast_ok;
    logic        fast_ge;
    logic [6:0]  earned_sat;
    logic [28:0] rem_sel;
    logic [7:0]  credit_sum;
    logic [32:0] sent_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_cap_reg         <= trcp_pkg::CREDIT_CAP_RESET;
            window_ticks_reg       <= trcp_pkg::WINDOW_TICKS_RESET;
            record_close_limit_reg <= trcp_pkg::RECORD_CLOSE_LIMIT_RESET;
            rekey_byte_limit_reg   <= trcp_pkg::REKEY_BYTE_LIMIT_RESET;
            rekey_record_limit_reg <= trcp_pkg::REKEY_RECORD_LIMIT_RESET;
            credit_earn_bytes_reg  <= trcp_pkg::CREDIT_EARN_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                trcp_pkg::CFG_CREDIT_CAP:         credit_cap_reg <= cfg_data[5:0];
                trcp_pkg::CFG_WINDOW_TICKS:       window_ticks_reg <= cfg_data;
                trcp_pkg::CFG_RECORD_CLOSE_LIMIT: record_close_limit_reg <= cfg_data[22:0];
                trcp_pkg::CFG_REKEY_BYTE_LIMIT:   rekey_byte_limit_reg <= cfg_data;
                trcp_pkg::CFG_REKEY_RECORD_LIMIT: rekey_record_limit_reg <= cfg_data[22:0];
                trcp_pkg::CFG_CREDIT_EARN_BYTES:  credit_earn_bytes_reg <= cfg_data[28:0];
                default: ;
            endcase
        end
    end

    // Handshake between the input register and the output register.
    assign compute_done  = !slow_needed || div_done;
    assign advance       = in_valid_reg && compute_done && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg        <= s_axis_tuser;
            in_direction_reg <= s_axis_tdata[0];
            in_kind_reg      <= s_axis_tdata[8:1];
            in_bytes_reg     <= s_axis_tdata[23:9];
            in_time_reg      <= s_axis_tdata[55:24];
        end
    end

    // Shared operands of the event logic.
    assign op            = trcp_pkg::op_t'(in_op_reg);
    assign active        = ready_reg && !closed_reg;
    assign block_bytes   = (in_bytes_reg > trcp_pkg::MAX_BLOCK_BYTES)
                         ? trcp_pkg::MAX_BLOCK_BYTES : in_bytes_reg;
    assign bytes_nonzero = (in_bytes_reg != 15'd0);
    assign is_update     = (in_kind_reg == trcp_pkg::KEY_UPDATE_KIND);
    assign record_sel    = in_direction_reg ? sent_record_count_reg
                                            : received_record_count_reg;
    assign record_inc    = (record_sel != trcp_pkg::RECORD_COUNT_MAX)
                         ? record_sel + 23'd1 : record_sel;
    assign elapsed       = in_time_reg - window_start_reg;
    assign credit_tmp    = (elapsed >= window_ticks_reg) ? credit_cap_reg : credit_count_reg;
    assign unit_eff      = (credit_earn_bytes_reg == 29'd0) ? 29'd1 : credit_earn_bytes_reg;
    assign rx_sum        = {1'b0, earned_byte_count_reg} + {15'd0, block_bytes};
    assign fast_ok       = ({1'b0, rx_sum} < {1'b0, unit_eff, 1'b0});
    assign fast_ge       = (rx_sum >= {1'b0, unit_eff});
    assign slow_needed   = in_valid_reg && active && (op == trcp_pkg::OP_RECEIVE)
                         && bytes_nonzero && !fast_ok;
    assign sent_sum      = {1'b0, sent_byte_count_reg} + {18'd0, block_bytes};

    always_comb
    begin
        if (!fast_ok)
        begin
            earned_sat = (|div_quot_reg[29:6]) ? 7'd64 : {1'b0, div_quot_reg[5:0]};
            rem_sel    = div_rem_reg;
        end
        else if (fast_ge)
        begin
            earned_sat = 7'd1;
            rem_sel    = rx_sum[28:0] - unit_eff;
        end
        else
        begin
            earned_sat = 7'd0;
            rem_sel    = rx_sum[28:0];
        end
    end

    assign credit_sum = {2'b00, credit_count_reg} + {1'b0, earned_sat};

    always_comb
    begin
        ready_next                 = ready_reg;
        closed_next                = closed_reg;
        sent_byte_count_next       = sent_byte_count_reg;
        sent_record_count_next     = sent_record_count_reg;
        received_record_count_next = received_record_count_reg;
        credit_count_next          = credit_count_reg;
        earned_byte_count_next     = earned_byte_count_reg;
        window_start_next          = window_start_reg;
        sent_rekey_count_next      = sent_rekey_count_reg;
        received_rekey_count_next  = received_rekey_count_reg;
        rekey                      = 1'b0;
        if (op == trcp_pkg::OP_READY)
        begin
            if (!closed_reg)
            begin
                ready_next = 1'b1;
            end
        end
        else if (active)
        begin
            case (op)
                trcp_pkg::OP_HEADER:
                begin
                    if (in_direction_reg)
                    begin
                        sent_record_count_next = record_inc;
                    end
                    else
                    begin
                        received_record_count_next = record_inc;
                    end
                    if (record_inc >= record_close_limit_reg)
                    begin
                        closed_next = 1'b1;
                        ready_next  = 1'b0;
                    end
                end
                trcp_pkg::OP_HANDSHAKE:
                begin
                    if (bytes_nonzero)
                    begin
                        if (!in_direction_reg)
                        begin
                            if (elapsed >= window_ticks_reg)
                            begin
                                window_start_next = in_time_reg;
                            end
                            if (credit_tmp == 6'd0 || !is_update)
                            begin
                                credit_count_next = credit_tmp;
                                closed_next       = 1'b1;
                                ready_next        = 1'b0;
                            end
                            else
                            begin
                                credit_count_next          = credit_tmp - 6'd1;
                                received_record_count_next = 23'd0;
                                received_rekey_count_next  =
                                    (received_rekey_count_reg == trcp_pkg::WORD_MAX)
                                    ? received_rekey_count_reg
                                    : received_rekey_count_reg + 32'd1;
                            end
                        end
                        else if (is_update)
                        begin
                            sent_byte_count_next   = 32'd0;
                            sent_record_count_next = 23'd0;
                            sent_rekey_count_next  =
                                (sent_rekey_count_reg == trcp_pkg::WORD_MAX)
                                ? sent_rekey_count_reg
                                : sent_rekey_count_reg + 32'd1;
                        end
                    end
                end
                trcp_pkg::OP_RECEIVE:
                begin
                    if (bytes_nonzero)
                    begin
                        earned_byte_count_next = rem_sel;
                        if (earned_sat != 7'd0)
                        begin
                            credit_count_next = (credit_sum > {2'b00, credit_cap_reg})
                                              ? credit_cap_reg : credit_sum[5:0];
                        end
                    end
                end
                trcp_pkg::OP_SEND:
                begin
                    if (bytes_nonzero)
                    begin
                        rekey = (sent_byte_count_reg >= rekey_byte_limit_reg)
                             || (sent_record_count_reg >= rekey_record_limit_reg);
                        sent_byte_count_next = sent_sum[32] ? trcp_pkg::WORD_MAX
                                                            : sent_sum[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg                 <= 1'b0;
            closed_reg                <= 1'b0;
            sent_byte_count_reg       <= 32'd0;
            sent_record_count_reg     <= 23'd0;
            received_record_count_reg <= 23'd0;
            credit_count_reg          <= trcp_pkg::CREDIT_CAP_RESET;
            earned_byte_count_reg     <= 29'd0;
            window_start_reg          <= 32'd0;
            sent_rekey_count_reg      <= 32'd0;
            received_rekey_count_reg  <= 32'd0;
        end
        else if (advance)
        begin
            ready_reg                 <= ready_next;
            closed_reg                <= closed_next;
            sent_byte_count_reg       <= sent_byte_count_next;
            sent_record_count_reg     <= sent_record_count_next;
            received_record_count_reg <= received_record_count_next;
            credit_count_reg          <= credit_count_next;
            earned_byte_count_reg     <= earned_byte_count_next;
            window_start_reg          <= window_start_next;
            sent_rekey_count_reg      <= sent_rekey_count_next;
            received_rekey_count_reg  <= received_rekey_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_closed_reg          <= closed_next;
            out_rekey_reg           <= rekey;
            out_credits_reg         <= credit_count_next;
            out_sent_rekeys_reg     <= sent_rekey_count_next;
            out_received_rekeys_reg <= received_rekey_count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_received_rekeys_reg, out_sent_rekeys_reg, out_credits_reg,
                            out_rekey_reg, out_closed_reg};

    // Restoring divider, one quotient bit per cycle, for large received-byte sums.
    assign div_last  = (div_count_reg == 5'(trcp_pkg::DIV_BITS - 1));
    assign div_trial = {div_rem_reg, div_dividend_reg[29]};
    assign div_ge    = (div_trial >= {1'b0, unit_eff});

    always_comb
    begin
        div_state_next = div_state_reg;
        case (div_state_reg)
            trcp_pkg::DIV_IDLE:
            begin
                if (slow_needed)
                begin
                    div_state_next = trcp_pkg::DIV_RUN;
                end
            end
            trcp_pkg::DIV_RUN:
            begin
                if (div_last)
                begin
                    div_state_next = trcp_pkg::DIV_DONE;
                end
            end
            trcp_pkg::DIV_DONE:
            begin
                if (advance)
                begin
                    div_state_next = trcp_pkg::DIV_IDLE;
                end
            end
            default: div_state_next = trcp_pkg::DIV_IDLE;
        endcase
    end

    always_comb
    begin
        div_load = (div_state_reg == trcp_pkg::DIV_IDLE) && slow_needed;
        div_done = (div_state_reg == trcp_pkg::DIV_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= trcp_pkg::DIV_IDLE;
            div_count_reg <= 5'd0;
        end
        else
        begin
            div_state_reg <= div_state_next;
            if (div_load)
            begin
                div_count_reg <= 5'd0;
            end
            else if (div_state_reg == trcp_pkg::DIV_RUN)
            begin
                div_count_reg <= div_count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_dividend_reg <= rx_sum;
            div_rem_reg      <= 29'd0;
            div_quot_reg     <= 30'd0;
        end
        else if (div_state_reg == trcp_pkg::DIV_RUN)
        begin
            div_dividend_reg <= {div_dividend_reg[28:0], 1'b0};
            div_rem_reg      <= div_ge ? 29'(div_trial - {1'b0, unit_eff}) : div_trial[28:0];
            div_quot_reg     <= {div_quot_reg[28:0], div_ge};
        end
    end

    `TRCP_ASSERT_NEXT(closed_sticky_a, clk, rst_n, closed_reg, closed_reg)
    `TRCP_ASSERT_SAME(closed_not_ready_a, clk, rst_n, closed_reg, !ready_reg)
    `TRCP_ASSERT_SAME(div_holds_input_a, clk, rst_n,
        div_state_reg == trcp_pkg::DIV_RUN, in_valid_reg && !s_axis_tready)
    `TRCP_ASSERT_NEXT(advance_fills_output_a, clk, rst_n, advance, out_valid_reg)

endmodule

// ----- verif/trcp_status_checker.sv -----
`timescale 1ns / 1ps

module trcp_status_checker
    import trcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          outstanding,
    output int          mismatch_count,
    output int          statuses_checked
);

    typedef struct packed {
        logic        closed;
        logic        rekey;
        logic [5:0]  credits;
        logic [31:0] sent_rekeys;
        logic [31:0] received_rekeys;
    } status_t;

    status_t expected_status[$];

    logic [5:0]  credit_cap;
    logic [31:0] window_ticks;
    logic [22:0] record_close_limit;
    logic [31:0] rekey_byte_limit;
    logic [22:0] rekey_record_limit;
    logic [28:0] credit_earn_bytes;

    logic        session_ready;
    logic        session_closed;
    logic [31:0] sent_bytes;
    logic [22:0] sent_records;
    logic [22:0] received_records;
    logic [5:0]  credits;
    logic [28:0] earned_bytes;
    logic [31:0] window_start;
    logic [31:0] sent_rekeys;
    logic [31:0] received_rekeys;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic status_t police_event(input logic [2:0] op, input logic outbound,
                                             input logic [7:0] kind,
                                             input logic [14:0] raw_bytes,
                                             input logic [31:0] now);
        logic [14:0] nbytes;
        logic        rekey;
        logic [22:0] records;
        logic [29:0] sum;
        logic [28:0] unit;
        logic [29:0] gained;
        logic [30:0] total;
        logic [32:0] wide;
        status_t     result;
        nbytes = (raw_bytes > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : raw_bytes;
        rekey = 1'b0;
        if (op == OP_READY)
        begin
            if (!session_closed)
            begin
                session_ready = 1'b1;
            end
        end
        else if (session_ready && !session_closed)
        begin
            case (op)
                OP_HEADER:
                begin
                    records = outbound ? sent_records : received_records;
                    if (records != RECORD_COUNT_MAX)
                    begin
                        records = records + 23'd1;
                    end
                    if (outbound)
                    begin
                        sent_records = records;
                    end
                    else
                    begin
                        received_records = records;
                    end
                    if (records >= record_close_limit)
                    begin
                        session_closed = 1'b1;
                        session_ready = 1'b0;
                    end
                end
                OP_HANDSHAKE:
                begin
                    if (nbytes != 0)
                    begin
                        if (!outbound && (now - window_start) >= window_ticks)
                        begin
                            credits = credit_cap;
                            window_start = now;
                        end
                        if (!outbound && (credits == 0 || kind != KEY_UPDATE_KIND))
                        begin
                            session_closed = 1'b1;
                            session_ready = 1'b0;
                        end
                        else
                        begin
                            if (!outbound)
                            begin
                                credits = credits - 6'd1;
                            end
                            if (kind == KEY_UPDATE_KIND && outbound)
                            begin
                                sent_bytes = '0;
                                sent_records = '0;
                                if (sent_rekeys != WORD_MAX)
                                begin
                                    sent_rekeys = sent_rekeys + 32'd1;
                                end
                            end
                            else if (kind == KEY_UPDATE_KIND)
                            begin
                                received_records = '0;
                                if (received_rekeys != WORD_MAX)
                                begin
                                    received_rekeys = received_rekeys + 32'd1;
                                end
                            end
                        end
                    end
                end
                OP_RECEIVE:
                begin
                    if (nbytes != 0)
                    begin
                        sum = {1'b0, earned_bytes} + 30'(nbytes);
                        unit = (credit_earn_bytes == 0) ? 29'd1 : credit_earn_bytes;
                        gained = sum / unit;
                        earned_bytes = 29'(sum % unit);
                        if (gained != 0)
                        begin
                            total = 31'(credits) + 31'(gained);
                            credits = (total > 31'(credit_cap)) ? credit_cap : total[5:0];
                        end
                    end
                end
                OP_SEND:
                begin
                    if (nbytes != 0)
                    begin
                        rekey = (sent_bytes >= rekey_byte_limit) ||
                                (sent_records >= rekey_record_limit);
                        wide = 33'(sent_bytes) + 33'(nbytes);
                        sent_bytes = (wide > 33'(WORD_MAX)) ? WORD_MAX : wide[31:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
        result.closed = session_closed;
        result.rekey = rekey;
        result.credits = credits;
        result.sent_rekeys = sent_rekeys;
        result.received_rekeys = received_rekeys;
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t want;
        status_t got;
        if (!rst_n)
        begin
            credit_cap = CREDIT_CAP_RESET;
            window_ticks = WINDOW_TICKS_RESET;
            record_close_limit = RECORD_CLOSE_LIMIT_RESET;
            rekey_byte_limit = REKEY_BYTE_LIMIT_RESET;
            rekey_record_limit = REKEY_RECORD_LIMIT_RESET;
            credit_earn_bytes = CREDIT_EARN_BYTES_RESET;
            session_ready = 1'b0;
            session_closed = 1'b0;
            sent_bytes = '0;
            sent_records = '0;
            received_records = '0;
            credits = CREDIT_CAP_RESET;
            earned_bytes = '0;
            window_start = '0;
            sent_rekeys = '0;
            received_rekeys = '0;
            expected_status.delete();
            mismatch_count = 0;
            statuses_checked = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CREDIT_CAP:         credit_cap = cfg_data[5:0];
                    CFG_WINDOW_TICKS:       window_ticks = cfg_data;
                    CFG_RECORD_CLOSE_LIMIT: record_close_limit = cfg_data[22:0];
                    CFG_REKEY_BYTE_LIMIT:   rekey_byte_limit = cfg_data;
                    CFG_REKEY_RECORD_LIMIT: rekey_record_limit = cfg_data[22:0];
                    CFG_CREDIT_EARN_BYTES:  credit_earn_bytes = cfg_data[28:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_status.push_back(police_event(s_axis_tuser, s_axis_tdata[0],
                                                       s_axis_tdata[8:1],
                                                       s_axis_tdata[23:9],
                                                       s_axis_tdata[55:24]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.closed = m_axis_tdata[0];
                got.rekey = m_axis_tdata[1];
                got.credits = m_axis_tdata[7:2];
                got.sent_rekeys = m_axis_tdata[39:8];
                got.received_rekeys = m_axis_tdata[71:40];
                statuses_checked++;
                if (expected_status.size() == 0)
                begin
                    report_mismatch("status with no request waiting", m_axis_tdata[31:0], '0);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got.closed !== want.closed)
                    begin
                        report_mismatch("session_closed", 32'(got.closed), 32'(want.closed));
                    end
                    if (got.rekey !== want.rekey)
                    begin
                        report_mismatch("rekey_needed", 32'(got.rekey), 32'(want.rekey));
                    end
                    if (got.credits !== want.credits)
                    begin
                        report_mismatch("credits_left", 32'(got.credits), 32'(want.credits));
                    end
                    if (got.sent_rekeys !== want.sent_rekeys)
                    begin
                        report_mismatch("sent_rekeys", got.sent_rekeys, want.sent_rekeys);
                    end
                    if (got.received_rekeys !== want.received_rekeys)
                    begin
                        report_mismatch("received_rekeys", got.received_rekeys,
                                        want.received_rekeys);
                    end
                end
            end
            outstanding <= expected_status.size();
        end
    end

endmodule

// ----- verif/tb_tls_rekey_credit_policer_unit.sv -----
`timescale 1ns / 1ps

module tb_tls_rekey_credit_policer_unit;
    import trcp_pkg::*;

    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
    localparam int         EVENTS_PER_SETTING = 160;
    localparam int         NOISE_EVENTS = 70;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int          outstanding;
    int          mismatch_count;
    int          statuses_checked;

    logic [31:0] now_ticks = '0;
    bit          quiet_sender = 1'b0;
    bit          quiet_sink = 1'b0;
    int          events_sent = 0;
    int          writes_done = 0;
    int          settings_used = 0;

    always #5 clk = ~clk;

    tls_rekey_credit_policer_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    trcp_status_checker u_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .outstanding      (outstanding),
        .mismatch_count   (mismatch_count),
        .statuses_checked (statuses_checked)
    );

    task automatic post_event(input logic [2:0] op, input logic outbound,
                              input logic [7:0] kind, input logic [14:0] nbytes);
        int gap;
        if (events_sent % 64 == 0)
        begin
            quiet_sender = ($urandom_range(0, 2) == 0);
        end
        gap = quiet_sender ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {now_ticks, nbytes, kind, outbound};
        do @(posedge clk); while (!s_axis_tready);
        events_sent++;
    endtask

    task automatic random_event(input bit well_formed);
        int          pick;
        int          size_pick;
        logic [2:0]  op;
        logic        outbound;
        logic [7:0]  kind;
        logic [14:0] nbytes;
        pick = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 19);
        outbound = 1'($urandom_range(0, 1));
        kind = 8'($urandom_range(0, 255));
        if (pick < 30)
            op = OP_HEADER;
        else if (pick < 50)
            op = OP_HANDSHAKE;
        else if (pick < 70)
            op = OP_RECEIVE;
        else if (pick < 95)
            op = OP_SEND;
        else if (pick < 97)
            op = OP_READY;
        else
            op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        if (op == OP_HANDSHAKE && ($urandom_range(0, 1) == 0 || (well_formed && !outbound)))
        begin
            kind = KEY_UPDATE_KIND;
        end
        if (size_pick == 0)
            nbytes = '0;
        else if (size_pick == 1)
            nbytes = MAX_BLOCK_BYTES;
        else if (size_pick == 2)
            nbytes = 15'($urandom_range(MAX_BLOCK_BYTES + 1, 15'h7FFF));
        else
            nbytes = 15'($urandom_range(1, MAX_BLOCK_BYTES));
        now_ticks = now_ticks + $urandom_range(1, 16);
        post_event(op, outbound, kind, nbytes);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        writes_done++;
    endtask

    task automatic load_setting(input logic [5:0] cap, input logic [31:0] window,
                                input logic [22:0] close_limit, input logic [31:0] byte_limit,
                                input logic [22:0] record_limit,
                                input logic [28:0] earn_bytes);
        drain();
        write_register(CFG_CREDIT_CAP, 32'(cap));
        write_register(CFG_WINDOW_TICKS, window);
        write_register(CFG_RECORD_CLOSE_LIMIT, 32'(close_limit));
        write_register(CFG_REKEY_BYTE_LIMIT, byte_limit);
        write_register(CFG_REKEY_RECORD_LIMIT, 32'(record_limit));
        write_register(CFG_CREDIT_EARN_BYTES, 32'(earn_bytes));
        cfg_valid <= 1'b0;
        settings_used++;
        now_ticks = now_ticks + window + $urandom_range(0, 32'h4000_0000);
    endtask

    initial
    begin : status_sink
        int stall;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 64 == 0)
            begin
                quiet_sink = ($urandom_range(0, 2) == 0);
            end
            stall = quiet_sink ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [5:0] cap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Events before the ready mark and reserved operation codes are ignored.
        post_event(OP_HEADER, 1'b0, 8'd0, 15'd0);
        post_event(OP_HANDSHAKE, 1'b0, 8'd0, 15'd5);
        post_event(OP_RECEIVE, 1'b1, 8'd0, MAX_BLOCK_BYTES);
        post_event(OP_SEND, 1'b0, 8'd0, 15'd100);
        post_event(OP_RESERVED_FIRST, 1'b1, KEY_UPDATE_KIND, 15'd1);
        post_event(OP_READY, 1'b0, 8'd0, 15'd0);
        post_event(OP_READY, 1'b1, 8'd255, 15'h7FFF);
        post_event(OP_RESERVED_LAST, 1'b0, KEY_UPDATE_KIND, 15'd1);
        post_event(OP_HEADER, 1'b1, 8'd0, 15'd0);
        post_event(OP_HEADER, 1'b0, 8'd0, 15'd0);
        post_event(OP_HANDSHAKE, 1'b0, KEY_UPDATE_KIND, 15'd0);
        now_ticks = 32'hFFFF_FFF0;
        post_event(OP_HANDSHAKE, 1'b0, KEY_UPDATE_KIND, 15'd1);
        post_event(OP_HANDSHAKE, 1'b1, 8'd255, 15'd40);
        post_event(OP_HANDSHAKE, 1'b1, KEY_UPDATE_KIND, 15'd4);
        post_event(OP_SEND, 1'b1, 8'd0, 15'd0);
        post_event(OP_SEND, 1'b0, 8'd0, 15'h7FFF);
        post_event(OP_RECEIVE, 1'b0, 8'd0, 15'd0);
        post_event(OP_RECEIVE, 1'b1, 8'd0, 15'h7FFF);
        now_ticks = 32'hFFFF_FFFF;
        post_event(OP_SEND, 1'b1, 8'd255, 15'd1);
        now_ticks = '0;
        post_event(OP_HANDSHAKE, 1'b0, KEY_UPDATE_KIND, MAX_BLOCK_BYTES);
        post_event(OP_HEADER, 1'b1, 8'd255, 15'h7FFF);

        // Windows never exceed the credit cap here, so received key updates always
        // find a credit and the session stays open.
        load_setting(6'd1, 32'd1, 23'd4194304, 32'd1, 23'd1, 29'd16384);
        repeat (EVENTS_PER_SETTING) random_event(1'b1);
        load_setting(6'd40, 32'd40, 23'd4194303, 32'd60000, 23'd6, 29'd200000);
        repeat (EVENTS_PER_SETTING) random_event(1'b1);
        load_setting(6'd20, 32'd20, 23'd4194304, 32'h8000_0000, 23'd4194304, 29'd16384);
        repeat (EVENTS_PER_SETTING) random_event(1'b1);
        load_setting(6'd63, 32'd63, 23'($urandom_range(100000, 4194304)),
                     $urandom_range(1, 200000), 23'($urandom_range(1, 30)), 29'd268435456);
        repeat (EVENTS_PER_SETTING) random_event(1'b1);
        repeat (2)
        begin
            cap = 6'($urandom_range(1, 63));
            load_setting(cap, $urandom_range(1, cap), 23'($urandom_range(100000, 4194304)),
                         $urandom_range(1, 300000), 23'($urandom_range(1, 40)),
                         29'($urandom_range(16384, 100000)));
            repeat (EVENTS_PER_SETTING) random_event(1'b1);
        end

        // Broken traffic may close the session; everything after that is ignored.
        load_setting(6'd1, 32'hFFFF_FFFF, 23'($urandom_range(1, 60)),
                     $urandom_range(1, 100000), 23'($urandom_range(1, 20)), 29'd16384);
        repeat (NOISE_EVENTS) random_event(1'b0);

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d events under %0d register settings using %0d register writes.",
                 events_sent, settings_used, writes_done);
        $display("Compared %0d status responses field by field.", statuses_checked);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
